### hw/rtl/numeric_format_converter_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef NUMERIC_FORMAT_CONVERTER_DEFINES_SVH
`define NUMERIC_FORMAT_CONVERTER_DEFINES_SVH

// Antecedent and consequent must hold in the same cycle.
`define NFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/nfc_pkg.sv
`default_nettype none
package nfc_pkg;

  // Action codes: source type times four plus destination type.
  localparam logic [3:0] ACT_I32_F32 = 4'd2;
  localparam logic [3:0] ACT_I32_F64 = 4'd3;
  localparam logic [3:0] ACT_I64_F64 = 4'd7;
  localparam logic [3:0] ACT_F32_I32 = 4'd8;
  localparam logic [3:0] ACT_F32_F64 = 4'd11;
  localparam logic [3:0] ACT_F64_I64 = 4'd13;
  localparam logic [3:0] ACT_F64_F32 = 4'd14;

  // How an item is finished at the last stage.
  localparam logic [1:0] KIND_SPECIAL = 2'd0;
  localparam logic [1:0] KIND_PACK    = 2'd1;
  localparam logic [1:0] KIND_TOINT   = 2'd2;

  localparam int unsigned F32_MAN = 23;
  localparam int unsigned F64_MAN = 52;

  typedef struct packed {
    logic [3:0]  action;
    logic [63:0] source_bits;
    logic        column_end;
  } nfc_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        handled;
    logic        column_end_out;
  } nfc_out_t;

  // After unpack: common significand form or a finished value.
  typedef struct packed {
    logic [1:0]         kind;
    logic               handled;
    logic               col_end;
    logic               dbl;
    logic               sign;
    logic [63:0]        sig;
    logic signed [13:0] exp2;
    logic [5:0]         rsh;
    logic [63:0]        spec;
  } nfc_s1_t;

  // After leading-zero count: biased exponent known.
  typedef struct packed {
    logic [1:0]         kind;
    logic               handled;
    logic               col_end;
    logic               dbl;
    logic               sign;
    logic [63:0]        sig;
    logic signed [13:0] be;
    logic [5:0]         lz;
    logic [5:0]         rsh;
    logic [63:0]        spec;
  } nfc_s2_t;

  // After alignment: ready to round or to negate.
  typedef struct packed {
    logic [1:0]  kind;
    logic        handled;
    logic        col_end;
    logic        dbl;
    logic        sign;
    logic [63:0] sig;
    logic        ovf;
    logic [6:0]  rsh;
    logic [10:0] base;
    logic [63:0] spec;
  } nfc_s3_t;

  // Leading zeros of a nonzero 64-bit word.
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return 6'd63 - idx;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/nfc_unpack.sv
`default_nettype none
module nfc_unpack (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire nfc_pkg::nfc_in_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output nfc_pkg::nfc_s1_t      data_o
);
  import nfc_pkg::*;

  nfc_s1_t     n;
  logic [31:0] lo;
  logic [7:0]  ef8;
  logic [22:0] mf23;
  logic [10:0] ef11;
  logic [51:0] mf52;
  logic [63:0] ival;
  logic        vld;

  assign lo   = data_i.source_bits[31:0];
  assign ef8  = lo[30:23];
  assign mf23 = lo[22:0];
  assign ef11 = data_i.source_bits[62:52];
  assign mf52 = data_i.source_bits[51:0];

  // Decode the pair and split the source into sign, significand and exponent.
  always_comb begin
    n = '0;
    n.handled = 1'b1;
    n.col_end = data_i.column_end;
    n.kind = KIND_SPECIAL;
    ival = (data_i.action == ACT_I64_F64) ? data_i.source_bits
                                          : {{32{lo[31]}}, lo};
    case (data_i.action)
      ACT_F32_F64: begin
        n.dbl = 1'b1;
        n.sign = lo[31];
        if (ef8 == 8'hFF) begin
          n.spec = {lo[31], 11'h7FF, mf23 | {(mf23 != '0), 22'b0}, 29'b0};
        end else if (ef8 == '0 && mf23 == '0) begin
          n.spec = {lo[31], 63'b0};
        end else begin
          n.kind = KIND_PACK;
          n.sig = {40'b0, (ef8 != '0), mf23};
          n.exp2 = ((ef8 == '0) ? 14'sd1 : $signed({6'b0, ef8})) - 14'sd150;
        end
      end
      ACT_F64_F32: begin
        n.sign = data_i.source_bits[63];
        if (ef11 == 11'h7FF) begin
          n.spec = {32'b0, n.sign, 8'hFF,
                    (mf52 == '0) ? 23'b0 : {1'b1, mf52[50:29]}};
        end else if (ef11 == '0 && mf52 == '0) begin
          n.spec = {32'b0, n.sign, 31'b0};
        end else begin
          n.kind = KIND_PACK;
          n.sig = {11'b0, (ef11 != '0), mf52};
          n.exp2 = ((ef11 == '0) ? 14'sd1 : $signed({3'b0, ef11})) - 14'sd1075;
        end
      end
      ACT_I32_F32, ACT_I32_F64, ACT_I64_F64: begin
        n.dbl = (data_i.action != ACT_I32_F32);
        n.sign = ival[63];
        if (ival != '0) begin
          n.kind = KIND_PACK;
          n.sig = ival[63] ? (64'd0 - ival) : ival;
        end
      end
      ACT_F32_I32: begin
        n.sign = lo[31];
        if (ef8 == 8'hFF && mf23 != '0) begin
          n.spec = '0;
        end else if (ef8 < 8'd127) begin
          n.spec = '0;
        end else if (ef8 >= 8'd158) begin
          n.spec = {32'b0, lo[31] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end else begin
          n.kind = KIND_TOINT;
          n.sig = {1'b1, mf23, 40'b0};
          n.rsh = 6'(8'd190 - ef8);
        end
      end
      ACT_F64_I64: begin
        n.dbl = 1'b1;
        n.sign = data_i.source_bits[63];
        if (ef11 == 11'h7FF && mf52 != '0) begin
          n.spec = '0;
        end else if (ef11 < 11'd1023) begin
          n.spec = '0;
        end else if (ef11 >= 11'd1086) begin
          n.spec = n.sign ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
          n.kind = KIND_TOINT;
          n.sig = {1'b1, mf52, 11'b0};
          n.rsh = 6'(11'd1086 - ef11);
        end
      end
      default: begin
        n.handled = 1'b0;
      end
    endcase
  end

  // Stage register.
  assign ready_o = !vld || ready_i;
  assign valid_o = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_o) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_o <= n;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/nfc_count.sv
`default_nettype none
module nfc_count (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire nfc_pkg::nfc_s1_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output nfc_pkg::nfc_s2_t      data_o
);
  import nfc_pkg::*;

  nfc_s2_t n;
  logic    vld;

  // Count leading zeros and form the biased exponent of the normalized value.
  always_comb begin
    n.kind    = data_i.kind;
    n.handled = data_i.handled;
    n.col_end = data_i.col_end;
    n.dbl     = data_i.dbl;
    n.sign    = data_i.sign;
    n.sig     = data_i.sig;
    n.rsh     = data_i.rsh;
    n.spec    = data_i.spec;
    n.lz      = lzc64(data_i.sig);
    n.be      = data_i.exp2 - $signed({8'b0, n.lz}) + 14'sd63
              + (data_i.dbl ? 14'sd1023 : 14'sd127);
  end

  assign ready_o = !vld || ready_i;
  assign valid_o = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_o) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_o <= n;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/nfc_shift.sv
`default_nettype none
module nfc_shift (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire nfc_pkg::nfc_s2_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output nfc_pkg::nfc_s3_t      data_o
);
  import nfc_pkg::*;

  nfc_s3_t            n;
  logic signed [13:0] emax;
  logic signed [13:0] norm_sh;
  logic signed [13:0] sub_sh;
  logic               vld;

  // Normalize the significand, or align the integer magnitude, and pick the
  // rounding shift: fixed for normal results, wider for subnormal ones.
  always_comb begin
    n.kind    = data_i.kind;
    n.handled = data_i.handled;
    n.col_end = data_i.col_end;
    n.dbl     = data_i.dbl;
    n.sign    = data_i.sign;
    n.spec    = data_i.spec;
    emax      = data_i.dbl ? 14'sd2047 : 14'sd255;
    norm_sh   = data_i.dbl ? 14'sd11 : 14'sd40;
    sub_sh    = norm_sh + 14'sd1 - data_i.be;
    n.ovf     = (data_i.be >= emax);
    if (data_i.kind == KIND_TOINT) begin
      n.sig = data_i.sig >> data_i.rsh;
    end else begin
      n.sig = data_i.sig << data_i.lz;
    end
    if (data_i.be >= 14'sd1) begin
      n.rsh  = 7'(norm_sh);
      n.base = 11'(data_i.be - 14'sd1);
    end else begin
      n.rsh  = (sub_sh > 14'sd65) ? 7'd65 : 7'(sub_sh);
      n.base = '0;
    end
  end

  assign ready_o = !vld || ready_i;
  assign valid_o = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_o) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_o <= n;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/nfc_round.sv
`default_nettype none
module nfc_round (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire nfc_pkg::nfc_s3_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output nfc_pkg::nfc_out_t     data_o
);
  import nfc_pkg::*;

  nfc_out_t     n;
  logic [129:0] wide;
  logic [63:0]  q;
  logic [63:0]  lim;
  logic [63:0]  mag;
  logic [63:0]  ival;
  logic         rnd;
  logic         sticky;
  logic         vld;

  // Round to nearest even, add the exponent and clamp to infinity; or finish
  // the integer by sign and width; or pass a finished special value through.
  always_comb begin
    wide   = {data_i.sig, 66'b0} >> data_i.rsh;
    rnd    = wide[65];
    sticky = |wide[64:0];
    q      = wide[129:66] + {63'b0, rnd && (sticky || wide[66])};
    lim    = data_i.dbl ? {1'b0, 11'h7FF, 52'b0} : {33'b0, 8'hFF, 23'b0};
    if (data_i.dbl) begin
      q = q + ({53'b0, data_i.base} << F64_MAN);
    end else begin
      q = q + ({53'b0, data_i.base} << F32_MAN);
    end
    mag  = (data_i.ovf || q >= lim) ? lim : q;
    ival = data_i.sign ? (64'd0 - data_i.sig) : data_i.sig;
    n.handled = data_i.handled;
    n.column_end_out = data_i.col_end;
    case (data_i.kind)
      KIND_PACK: begin
        n.result_bits = data_i.dbl ? {data_i.sign, mag[62:0]}
                                   : {32'b0, data_i.sign, mag[30:0]};
      end
      KIND_TOINT: begin
        n.result_bits = data_i.dbl ? ival : {32'b0, ival[31:0]};
      end
      default: begin
        n.result_bits = data_i.spec;
      end
    endcase
  end

  // Output register; it holds a finished result while the next one forms.
  assign ready_o = !vld || ready_i;
  assign valid_o = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_o) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_o <= n;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/numeric_format_converter.sv
`default_nettype none
// Converts one column element per cycle between i32, i64, f32 and f64 as
// selected by the action code, with round to nearest even for float results
// and truncation with saturation for integer results. The pipeline has four
// register stages (unpack, leading-zero count, align, round); one item can
// enter every cycle, and a stall on the result side holds every occupied
// stage without loss.
`include "numeric_format_converter_defines.svh"
module numeric_format_converter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire nfc_pkg::nfc_in_t  item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output nfc_pkg::nfc_out_t      result
);
  import nfc_pkg::*;

  nfc_s1_t s1;
  nfc_s2_t s2;
  nfc_s3_t s3;
  logic    s1_valid, s1_ready;
  logic    s2_valid, s2_ready;
  logic    s3_valid, s3_ready;

  nfc_unpack u_unpack (
    .clk(clk), .rst(rst),
    .valid_i(item_valid), .ready_o(item_ready), .data_i(item),
    .valid_o(s1_valid), .ready_i(s1_ready), .data_o(s1)
  );

  nfc_count u_count (
    .clk(clk), .rst(rst),
    .valid_i(s1_valid), .ready_o(s1_ready), .data_i(s1),
    .valid_o(s2_valid), .ready_i(s2_ready), .data_o(s2)
  );

  nfc_shift u_shift (
    .clk(clk), .rst(rst),
    .valid_i(s2_valid), .ready_o(s2_ready), .data_i(s2),
    .valid_o(s3_valid), .ready_i(s3_ready), .data_o(s3)
  );

  nfc_round u_round (
    .clk(clk), .rst(rst),
    .valid_i(s3_valid), .ready_o(s3_ready), .data_i(s3),
    .valid_o(result_valid), .ready_i(result_ready), .data_o(result)
  );

  // An unsupported pair always yields zero bits.
  `NFC_ASSERT_SAME(a_unhandled_zero, result_valid && !result.handled, result.result_bits == 64'd0, "unhandled pair gave nonzero bits")
  // A transfer in always lands in the first stage.
  `NFC_ASSERT_NEXT(a_enter_stage, item_valid && item_ready, s1_valid, "accepted item lost at entry")
  // Input backpressure only comes from a full, stalled pipeline.
  `NFC_ASSERT_SAME(a_stall_cause, !item_ready, result_valid && !result_ready && s1_valid && s2_valid && s3_valid, "input stalled without a full pipeline")
endmodule
`default_nettype wire
